// ===== rtl/core/pet_pkg.sv =====
package pet_pkg;

    localparam int THRESHOLD_W   = 24;
    localparam int COUNT_W       = 24;
    localparam int APB_ADDR_W    = 4;
    localparam int APB_DATA_W    = 32;
    localparam int STATUS_W      = 3;

    localparam int DEF_SAMPLE_BITS = 24;
    localparam int DEF_INDEX_BITS  = 24;

    // 1.5 V on a +-10 V 24-bit scale
    localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 24'd1258291;
    localparam logic                   CHECK_MODE_RESET = 1'b0;
    localparam logic [COUNT_W-1:0]     SAMPLE_COUNT_RESET = 24'd1000;

    localparam logic [1:0] REG_THRESHOLD    = 2'd0;
    localparam logic [1:0] REG_CHECK_MODE   = 2'd1;
    localparam logic [1:0] REG_SAMPLE_COUNT = 2'd2;

    localparam logic [1:0] LEVEL_LOW     = 2'd0;
    localparam logic [1:0] LEVEL_HIGH    = 2'd1;
    localparam logic [1:0] LEVEL_UNKNOWN = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_MEASURE_OK       = 3'd0,
        ST_MEASURE_DOUBTFUL = 3'd1,
        ST_MEASURE_FAILED   = 3'd2,
        ST_CHECK_OK         = 3'd3,
        ST_CHECK_FAILED     = 3'd4
    } status_t;

    typedef struct packed {
        logic signed [THRESHOLD_W-1:0] threshold;
        logic                          check_mode;
        logic [COUNT_W-1:0]            sample_count;
    } cfg_t;

endpackage

// ===== rtl/core/pet_regs.sv =====
module pet_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pet_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [pet_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [pet_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    output pet_pkg::cfg_t                       cfg
);

    pet_pkg::cfg_t cfg_reg;
    logic [1:0]    reg_idx;
    logic          wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold    <= pet_pkg::THRESHOLD_RESET;
            cfg_reg.check_mode   <= pet_pkg::CHECK_MODE_RESET;
            cfg_reg.sample_count <= pet_pkg::SAMPLE_COUNT_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                pet_pkg::REG_THRESHOLD:
                    cfg_reg.threshold <= pwdata[pet_pkg::THRESHOLD_W-1:0];
                pet_pkg::REG_CHECK_MODE:
                    cfg_reg.check_mode <= pwdata[0];
                pet_pkg::REG_SAMPLE_COUNT:
                    cfg_reg.sample_count <= pwdata[pet_pkg::COUNT_W-1:0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            pet_pkg::REG_THRESHOLD:
                prdata = pet_pkg::APB_DATA_W'(unsigned'(cfg_reg.threshold));
            pet_pkg::REG_CHECK_MODE:
                prdata = pet_pkg::APB_DATA_W'(cfg_reg.check_mode);
            pet_pkg::REG_SAMPLE_COUNT:
                prdata = pet_pkg::APB_DATA_W'(cfg_reg.sample_count);
            default:
                prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/pet_tracker.sv =====
module pet_tracker
#(
    parameter int SAMPLE_BITS = pet_pkg::DEF_SAMPLE_BITS,
    parameter int INDEX_BITS  = pet_pkg::DEF_INDEX_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  pet_pkg::cfg_t                 cfg,
    input  logic                          step,
    input  logic [SAMPLE_BITS-1:0]        sample,
    output logic                          is_last,
    output pet_pkg::status_t              status,
    output logic [INDEX_BITS-1:0]         first_edge_index,
    output logic signed [INDEX_BITS:0]    pulse_length,
    output logic [INDEX_BITS-1:0]         fail_index,
    output logic                          fail_level
);

    localparam int CMP_W = (INDEX_BITS + 1 > pet_pkg::COUNT_W) ? INDEX_BITS + 1
                                                               : pet_pkg::COUNT_W;

    logic [INDEX_BITS-1:0] counter_reg, counter_next;
    logic [1:0]            prev_reg, prev_next;
    logic                  fall_seen_reg, fall_seen_next;
    logic [INDEX_BITS-1:0] fall_idx_reg, fall_idx_next;
    logic                  rise_seen_reg, rise_seen_next;
    logic [INDEX_BITS-1:0] rise_idx_reg, rise_idx_next;
    logic                  fail_seen_reg, fail_seen_next;
    logic [INDEX_BITS-1:0] fail_idx_reg, fail_idx_next;
    logic                  fail_lvl_reg, fail_lvl_next;

    logic signed [SAMPLE_BITS-1:0] sample_s;
    logic                          level;
    logic [1:0]                    level2;
    logic [INDEX_BITS:0]           count_inc;
    logic                          both;

    assign sample_s  = sample;
    assign level     = (sample_s > cfg.threshold);
    assign level2    = {1'b0, level};
    assign count_inc = {1'b0, counter_reg} + {{INDEX_BITS{1'b0}}, 1'b1};
    assign is_last   = (CMP_W'(count_inc) >= CMP_W'(cfg.sample_count));

    // edge and alternation tracking for the current sample
    always_comb
    begin
        prev_next      = prev_reg;
        fall_seen_next = fall_seen_reg;
        fall_idx_next  = fall_idx_reg;
        rise_seen_next = rise_seen_reg;
        rise_idx_next  = rise_idx_reg;
        fail_seen_next = fail_seen_reg;
        fail_idx_next  = fail_idx_reg;
        fail_lvl_next  = fail_lvl_reg;

        if (!cfg.check_mode)
        begin
            if (!level && prev_reg == pet_pkg::LEVEL_UNKNOWN)
            begin
                fall_seen_next = 1'b1;
                fall_idx_next  = '0;
            end
            else if (!level && prev_reg == pet_pkg::LEVEL_HIGH)
            begin
                if (!fall_seen_reg)
                begin
                    fall_seen_next = 1'b1;
                    fall_idx_next  = counter_reg;
                end
                else
                begin
                    fail_seen_next = 1'b1;
                    fail_idx_next  = counter_reg;
                end
            end
            else if (level && prev_reg == pet_pkg::LEVEL_LOW)
            begin
                if (!rise_seen_reg)
                begin
                    rise_seen_next = 1'b1;
                    rise_idx_next  = counter_reg;
                end
                else
                begin
                    fail_seen_next = 1'b1;
                    fail_idx_next  = counter_reg;
                end
            end
            prev_next = level2;
        end
        else if (!fail_seen_reg)
        begin
            if (level2 == prev_reg)
            begin
                fail_seen_next = 1'b1;
                fail_idx_next  = counter_reg;
                fail_lvl_next  = level;
            end
            else
            begin
                prev_next = level2;
            end
        end

        counter_next = count_inc[INDEX_BITS-1:0];
    end

    // summary from the updated state
    assign both = fall_seen_next && rise_seen_next;

    always_comb
    begin
        if (!cfg.check_mode)
        begin
            status = both ? (fail_seen_next ? pet_pkg::ST_MEASURE_DOUBTFUL
                                            : pet_pkg::ST_MEASURE_OK)
                          : pet_pkg::ST_MEASURE_FAILED;
            first_edge_index = fall_seen_next ? fall_idx_next : '0;
            pulse_length     = both ? ({1'b0, rise_idx_next} - {1'b0, fall_idx_next}) : '0;
            fail_index       = fail_seen_next ? fail_idx_next : '0;
            fail_level       = 1'b0;
        end
        else
        begin
            status = fail_seen_next ? pet_pkg::ST_CHECK_FAILED : pet_pkg::ST_CHECK_OK;
            first_edge_index = '0;
            pulse_length     = '0;
            fail_index       = fail_seen_next ? fail_idx_next : '0;
            fail_level       = fail_seen_next ? fail_lvl_next : 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg   <= '0;
            prev_reg      <= pet_pkg::LEVEL_UNKNOWN;
            fall_seen_reg <= 1'b0;
            fall_idx_reg  <= '0;
            rise_seen_reg <= 1'b0;
            rise_idx_reg  <= '0;
            fail_seen_reg <= 1'b0;
            fail_idx_reg  <= '0;
            fail_lvl_reg  <= 1'b0;
        end
        else if (step)
        begin
            if (is_last)
            begin
                counter_reg   <= '0;
                prev_reg      <= pet_pkg::LEVEL_UNKNOWN;
                fall_seen_reg <= 1'b0;
                fall_idx_reg  <= '0;
                rise_seen_reg <= 1'b0;
                rise_idx_reg  <= '0;
                fail_seen_reg <= 1'b0;
                fail_idx_reg  <= '0;
                fail_lvl_reg  <= 1'b0;
            end
            else
            begin
                counter_reg   <= counter_next;
                prev_reg      <= prev_next;
                fall_seen_reg <= fall_seen_next;
                fall_idx_reg  <= fall_idx_next;
                rise_seen_reg <= rise_seen_next;
                rise_idx_reg  <= rise_idx_next;
                fail_seen_reg <= fail_seen_next;
                fail_idx_reg  <= fail_idx_next;
                fail_lvl_reg  <= fail_lvl_next;
            end
        end
    end

`ifndef ASSERT_OFF
    a_wrap_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (step && is_last) |=> (counter_reg == '0 && prev_reg == pet_pkg::LEVEL_UNKNOWN))
        else $error("acquisition state not cleared after summary");

    a_prev_known: assert property (@(posedge clk) disable iff (!rst_n)
        (counter_reg != '0) |-> (prev_reg != pet_pkg::LEVEL_UNKNOWN))
        else $error("level unknown past first sample");
`endif

endmodule

// ===== rtl/core/pulse_edge_timing_checker.sv =====
// Pulse edge timing checker.
// Input stream s_axis: one signed ADC sample per item in tdata. A sample
// above the threshold register is logic high. Every sample_count samples
// the block emits one summary item on m_axis (status in tuser; edge, pulse
// and failure indices in tdata) and starts a new acquisition; other samples
// produce no item.
// Registers over APB: 0x0 threshold, 0x4 check_mode, 0x8 sample_count.
// Write registers only while no acquisition is in flight.
// Throughput: one sample per cycle while s_axis_tready stays high. A
// sample sits in the input register, where edge tracking and the summary
// are evaluated; when the final sample advances, the summary is loaded
// into the output register, which drives m_axis_tvalid until the summary
// is taken.
// While m_axis is stalled, samples that do not end an acquisition still
// advance; the final sample of the next acquisition waits in the input
// register and s_axis_tready drops until the summary is taken.
// Reset restores the register defaults, empties both stages and clears
// the acquisition state.
module pulse_edge_timing_checker
#(
    parameter int SAMPLE_BITS = pet_pkg::DEF_SAMPLE_BITS,
    parameter int INDEX_BITS  = pet_pkg::DEF_INDEX_BITS
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [pet_pkg::APB_ADDR_W-1:0]          paddr,
    input  logic [pet_pkg::APB_DATA_W-1:0]          pwdata,
    output logic [pet_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                    pready,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // sample
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]        s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // first_edge_index, pulse_length, fail_index, fail_level
    output logic [((3*INDEX_BITS+2+7)/8)*8-1:0]     m_axis_tdata,
    // status
    output logic [pet_pkg::STATUS_W-1:0]            m_axis_tuser
);

    pet_pkg::cfg_t cfg;

    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   is_last;
    logic                   advance;
    logic                   out_free;

    pet_pkg::status_t             res_status;
    logic [INDEX_BITS-1:0]        res_first;
    logic signed [INDEX_BITS:0]   res_pulse;
    logic [INDEX_BITS-1:0]        res_fail_idx;
    logic                         res_fail_lvl;

    logic                         out_valid_reg;
    pet_pkg::status_t             status_reg;
    logic [INDEX_BITS-1:0]        first_reg;
    logic [INDEX_BITS:0]          pulse_reg;
    logic [INDEX_BITS-1:0]        fail_idx_reg;
    logic                         fail_lvl_reg;

    pet_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pet_tracker #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .INDEX_BITS  (INDEX_BITS)
    ) u_tracker
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .step             (advance),
        .sample           (sample_reg),
        .is_last          (is_last),
        .status           (res_status),
        .first_edge_index (res_first),
        .pulse_length     (res_pulse),
        .fail_index       (res_fail_idx),
        .fail_level       (res_fail_lvl)
    );

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!is_last || out_free);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            sample_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && is_last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && is_last)
        begin
            status_reg   <= res_status;
            first_reg    <= res_first;
            pulse_reg    <= res_pulse;
            fail_idx_reg <= res_fail_idx;
            fail_lvl_reg <= res_fail_lvl;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = status_reg;

    always_comb
    begin
        m_axis_tdata = '0;
        m_axis_tdata[INDEX_BITS-1:0]                = first_reg;
        m_axis_tdata[2*INDEX_BITS:INDEX_BITS]       = pulse_reg;
        m_axis_tdata[3*INDEX_BITS:2*INDEX_BITS+1]   = fail_idx_reg;
        m_axis_tdata[3*INDEX_BITS+1]                = fail_lvl_reg;
    end

`ifndef ASSERT_OFF
    a_summary_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && is_last) |=> m_axis_tvalid)
        else $error("summary not presented after final sample");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !(advance && is_last))
        else $error("pending summary overwritten");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && is_last && out_valid_reg))
        else $error("input stalled without a blocked summary");
`endif

endmodule

// ===== tb/tb_pulse_edge_timing_checker.sv =====
module tb_pulse_edge_timing_checker;

    timeunit 1ns;
    timeprecision 1ps;

    import pet_pkg::*;

    localparam int SAMPLE_W   = DEF_SAMPLE_BITS;
    localparam int IDX_W      = DEF_INDEX_BITS;
    localparam int S_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((3 * IDX_W + 2 + 7) / 8) * 8;
    localparam int SAMPLE_MIN = -(1 << (SAMPLE_W - 1));
    localparam int SAMPLE_MAX = (1 << (SAMPLE_W - 1)) - 1;
    localparam int STALL_HOLD = 80;

    // address 0xC, no register behind it
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        status_t           status;
        logic [IDX_W-1:0]  first_edge;
        logic [IDX_W:0]    pulse_len;
        logic [IDX_W-1:0]  fail_idx;
        logic              fail_lvl;
    } summary_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_ADDR_W-1:0]     paddr;
    logic [APB_DATA_W-1:0]     pwdata;
    logic [APB_DATA_W-1:0]     prdata;
    logic                      pready;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    // sample
    logic [S_TDATA_W-1:0]      s_axis_tdata;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    // first_edge_index, pulse_length, fail_index, fail_level
    logic [M_TDATA_W-1:0]      m_axis_tdata;
    // status
    logic [STATUS_W-1:0]       m_axis_tuser;

    // register mirror
    logic signed [THRESHOLD_W-1:0] cfg_threshold;
    logic                          cfg_check_mode;
    logic [COUNT_W-1:0]            cfg_sample_count;

    // acquisition state of the predictor
    logic [IDX_W-1:0] acq_index;
    logic [1:0]       prev_lvl;
    logic             fall_seen;
    logic [IDX_W-1:0] fall_idx;
    logic             rise_seen;
    logic [IDX_W-1:0] rise_idx;
    logic             fail_seen;
    logic [IDX_W-1:0] fail_idx;
    logic             fail_lvl;

    summary_t pending_summaries[$];

    int unsigned mismatches;
    int unsigned samples_sent;
    int unsigned summaries_checked;
    int unsigned reg_writes;
    bit          tx_steady;
    bit          rx_steady;
    bit          hold_req;
    int          stall_left;

    pulse_edge_timing_checker u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 clk = ~clk;

    function automatic void restart_acquisition();
        acq_index = '0;
        prev_lvl  = LEVEL_UNKNOWN;
        fall_seen = 1'b0;
        fall_idx  = '0;
        rise_seen = 1'b0;
        rise_idx  = '0;
        fail_seen = 1'b0;
        fail_idx  = '0;
        fail_lvl  = 1'b0;
    endfunction

    // Advances the edge tracker by one sample; queues a summary when the
    // acquisition ends.
    function automatic void track_sample(input logic signed [SAMPLE_W-1:0] smp);
        logic       lvl;
        logic [1:0] lvl_code;
        logic [IDX_W:0] nxt;
        summary_t   sm;
        lvl = (smp > cfg_threshold);
        lvl_code = {1'b0, lvl};
        if (!cfg_check_mode) begin
            if (!lvl && prev_lvl == LEVEL_UNKNOWN) begin
                fall_seen = 1'b1;
                fall_idx  = '0;
            end
            else if (!lvl && prev_lvl == LEVEL_HIGH) begin
                if (!fall_seen) begin
                    fall_seen = 1'b1;
                    fall_idx  = acq_index;
                end
                else begin
                    fail_seen = 1'b1;
                    fail_idx  = acq_index;
                end
            end
            else if (lvl && prev_lvl == LEVEL_LOW) begin
                if (!rise_seen) begin
                    rise_seen = 1'b1;
                    rise_idx  = acq_index;
                end
                else begin
                    fail_seen = 1'b1;
                    fail_idx  = acq_index;
                end
            end
            prev_lvl = lvl_code;
        end
        else if (!fail_seen) begin
            if (lvl_code == prev_lvl) begin
                fail_seen = 1'b1;
                fail_idx  = acq_index;
                fail_lvl  = lvl;
            end
            else begin
                prev_lvl = lvl_code;
            end
        end

        nxt = {1'b0, acq_index} + 1'b1;
        if (nxt < {1'b0, cfg_sample_count}) begin
            acq_index = nxt[IDX_W-1:0];
            return;
        end

        sm = '0;
        if (!cfg_check_mode) begin
            if (!(fall_seen && rise_seen))
                sm.status = ST_MEASURE_FAILED;
            else if (fail_seen)
                sm.status = ST_MEASURE_DOUBTFUL;
            else
                sm.status = ST_MEASURE_OK;
            sm.first_edge = fall_seen ? fall_idx : '0;
            if (fall_seen && rise_seen)
                sm.pulse_len = {1'b0, rise_idx} - {1'b0, fall_idx};
            sm.fail_idx = fail_seen ? fail_idx : '0;
        end
        else begin
            sm.status   = fail_seen ? ST_CHECK_FAILED : ST_CHECK_OK;
            sm.fail_idx = fail_seen ? fail_idx : '0;
            sm.fail_lvl = fail_seen ? fail_lvl : 1'b0;
        end
        pending_summaries.push_back(sm);
        restart_acquisition();
    endfunction

    function automatic int pick_gap();
        int r;
        if (tx_steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Random ADC code on the requested side of the threshold; a low code when no code lies above it.
    function automatic logic signed [SAMPLE_W-1:0] level_sample(input logic hi);
        int t;
        int lo_b;
        int hi_b;
        int v;
        t = int'(cfg_threshold);
        if (hi && t < SAMPLE_MAX) begin
            lo_b = t + 1;
            hi_b = SAMPLE_MAX;
        end
        else begin
            lo_b = SAMPLE_MIN;
            hi_b = t;
        end
        case ($urandom_range(0, 3))
            0:       v = hi ? lo_b : hi_b;
            1:       v = hi ? hi_b : lo_b;
            default: v = lo_b + int'($urandom_range(0, hi_b - lo_b));
        endcase
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic flag_error(input string msg);
        if (mismatches < 10)
            $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [IDX_W:0] want,
                               input logic [IDX_W:0] got);
        if (got !== want)
            flag_error($sformatf("summary %0d %s expected %0h got %0h",
                                 summaries_checked, name, want, got));
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_THRESHOLD:    cfg_threshold    = value[THRESHOLD_W-1:0];
            REG_CHECK_MODE:   cfg_check_mode   = value[0];
            REG_SAMPLE_COUNT: cfg_sample_count = value[COUNT_W-1:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        do @(posedge clk); while (!s_axis_tready);
        track_sample(smp);
        samples_sent++;
    endtask

    // Stop sending, let every summary come out, then let the pipe empty.
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_summaries.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_config(input logic [31:0] thr, input logic mode,
                              input logic [31:0] cnt);
        wait_drained();
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_CHECK_MODE, {31'd0, mode});
        write_reg(REG_SAMPLE_COUNT, cnt);
    endtask

    // Reset values: one sample each side of the default threshold, then a
    // short count closes the acquisition on the next sample.
    task automatic test_reset_defaults();
        send_sample(24'sd1258292);
        send_sample(24'sd1258291);
        wait_drained();
        write_reg(REG_SAMPLE_COUNT, 32'd2);
        send_sample(24'sd1258292);
    endtask

    task automatic test_measure_extremes();
        // lowest threshold: fall, rise, then one spurious edge of each kind
        set_config(32'h0080_0000, 1'b0, 32'd4);
        send_sample(-24'sd8388608);
        send_sample(24'sd8388607);
        send_sample(-24'sd8388608);
        send_sample(-24'sd8388607);
        // highest threshold: nothing can be high, no rising edge
        set_config(32'h007F_FFFF, 1'b0, 32'd3);
        send_sample(24'sd8388607);
        send_sample(24'sd0);
        send_sample(-24'sd1);
    endtask

    // Check mode leaves a known low level behind; measure mode then sees the
    // rise before the fall and the pulse length goes negative.
    task automatic test_mode_switch();
        set_config(32'd0, 1'b1, 32'd4);
        send_sample(-24'sd5);
        wait_drained();
        write_reg(REG_CHECK_MODE, 32'hFFFF_FFFE);
        send_sample(24'sd100);
        send_sample(-24'sd100);
        send_sample(24'sd0);
    endtask

    task automatic test_check_mode();
        set_config(32'd0, 1'b1, 32'd5);
        send_sample(24'sd1);
        send_sample(-24'sd1);
        send_sample(24'sd1);
        send_sample(24'sd1);
        send_sample(-24'sd1);
        set_config(32'd0, 1'b1, 32'd4);
        send_sample(-24'sd1);
        send_sample(24'sd1);
        send_sample(-24'sd1);
        send_sample(24'sd1);
    endtask

    task automatic test_short_acquisitions();
        set_config(32'd0, 1'b0, 32'd0);
        send_sample(-24'sd1);
        wait_drained();
        write_reg(REG_UNUSED, 32'h0000_0007);
        set_config(32'd0, 1'b1, 32'd1);
        send_sample(24'sd5);
    endtask

    // Receiver holds off long enough for the block to back up into s_axis.
    task automatic test_output_stall();
        int j;
        set_config(32'd0, 1'b0, 32'd2);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        hold_req  = 1'b1;
        for (j = 0; j < 24; j++)
            send_sample(level_sample(j[1] ^ j[0]));
        wait_drained();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    task automatic test_random_acquisitions();
        int unsigned start_checked;
        int unsigned sent;
        int          sel;
        int          cnt;
        int          win;
        int          n_items;
        int          pat;
        int          pos;
        int          hi_len;
        int          lo_len;
        int          j;
        logic [31:0] thr_word;
        logic        lvl;
        logic signed [SAMPLE_W-1:0] smp;
        start_checked = summaries_checked;
        sent = 0;
        hi_len = 0;
        lo_len = 1;
        while (sent < 575 || summaries_checked - start_checked < 40) begin
            wait_drained();
            sel = $urandom_range(0, 9);
            if (sel == 0)
                thr_word = 32'h0080_0000;
            else if (sel == 1)
                thr_word = 32'h007F_FFFF;
            else if (sel < 5)
                thr_word = $urandom_range(0, 2000) - 1000;
            else
                thr_word = $urandom;
            write_reg(REG_THRESHOLD, thr_word);
            write_reg(REG_CHECK_MODE, $urandom);
            sel = $urandom_range(0, 19);
            if (sel == 0)
                cnt = $urandom_range(0, 1);
            else if (sel == 1)
                cnt = 24'hFF_FFFF;
            else if (sel == 2)
                cnt = $urandom_range(25, 24'hFF_FFFF);
            else
                cnt = $urandom_range(2, 24);
            write_reg(REG_SAMPLE_COUNT, cnt);
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_UNUSED, $urandom);

            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            win = (cnt >= 2 && cnt <= 24) ? cnt : 8;
            n_items = (cnt >= 2 && cnt <= 24) ? cnt * $urandom_range(1, 3)
                                              : $urandom_range(3, 12);
            pat = $urandom_range(0, 9);
            lvl = 1'($urandom);
            for (j = 0; j < n_items; j++) begin
                pos = j % win;
                if (pat < 4) begin
                    // square wave, now and then a repeated level
                    if ($urandom_range(0, 19) != 0)
                        lvl = ~lvl;
                    smp = level_sample(lvl);
                end
                else if (pat < 8) begin
                    // high, low pulse, high again, with rare glitches
                    if (pos == 0) begin
                        hi_len = $urandom_range(0, win / 3);
                        lo_len = $urandom_range(1, win / 2);
                    end
                    lvl = !(pos >= hi_len && pos < hi_len + lo_len);
                    if ($urandom_range(0, 24) == 0)
                        lvl = ~lvl;
                    smp = level_sample(lvl);
                end
                else begin
                    smp = SAMPLE_W'($urandom);
                end
                send_sample(smp);
                sent++;
                if ($urandom_range(0, 99) == 0)
                    wait_drained();
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    task automatic sel_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            stall_left = $urandom_range(10, 40);
        else if (r < 15)
            stall_left = $urandom_range(1, 3);
    endtask

    // receiver: random stalls, plus a long hold on request
    initial begin
        m_axis_tready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                stall_left = STALL_HOLD;
            end
            else if (stall_left == 0 && !rx_steady) begin
                sel_stall();
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin : summary_monitor
        summary_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_summaries.size() == 0) begin
                flag_error($sformatf("unexpected summary status %0d tdata %0h",
                                     m_axis_tuser, m_axis_tdata));
            end
            else begin
                want = pending_summaries.pop_front();
                check_field("status", (IDX_W+1)'(want.status),
                            (IDX_W+1)'(m_axis_tuser));
                check_field("first_edge_index", (IDX_W+1)'(want.first_edge),
                            (IDX_W+1)'(m_axis_tdata[IDX_W-1:0]));
                check_field("pulse_length", want.pulse_len,
                            m_axis_tdata[2*IDX_W:IDX_W]);
                check_field("fail_index", (IDX_W+1)'(want.fail_idx),
                            (IDX_W+1)'(m_axis_tdata[3*IDX_W:2*IDX_W+1]));
                check_field("fail_level", (IDX_W+1)'(want.fail_lvl),
                            (IDX_W+1)'(m_axis_tdata[3*IDX_W+1]));
            end
            summaries_checked++;
        end
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        tx_steady     = 1'b0;
        rx_steady     = 1'b0;
        hold_req      = 1'b0;
        mismatches        = 0;
        samples_sent      = 0;
        summaries_checked = 0;
        reg_writes        = 0;
        cfg_threshold    = THRESHOLD_RESET;
        cfg_check_mode   = CHECK_MODE_RESET;
        cfg_sample_count = SAMPLE_COUNT_RESET;
        restart_acquisition();
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_measure_extremes();
        test_mode_switch();
        test_check_mode();
        test_short_acquisitions();
        test_output_stall();
        test_random_acquisitions();

        wait_drained();
        repeat (10) @(negedge clk);
        $display("Sent %0d samples, checked %0d summaries, %0d register writes.",
                 samples_sent, summaries_checked, reg_writes);
        $display("Both modes, threshold and count extremes, mode switch, stalls.");
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
